>>> design/spherical_pair_to_ray_unit_defines.svh
// Assertion macros used by the checker of the spherical pair to ray unit.
`ifndef SPHERICAL_PAIR_TO_RAY_UNIT_DEFINES_SVH
`define SPHERICAL_PAIR_TO_RAY_UNIT_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spr check failed: next-cycle rule");

// The consequent must hold in the same cycle as the antecedent.
`define SPR_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spr check failed: same-cycle rule");

`endif

>>> design/spr_pkg.sv
// Package with constants, tables and types of the spherical pair to ray unit.
`default_nettype none
package spr_pkg;

	// Number of CORDIC rotations, capped by the arctangent table length.
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

	// Widths of the internal values.
	localparam int AW   = 18;  // reduced angle, Q3.14
	localparam int XW   = 34;  // CORDIC x and y, Q30
	localparam int ZW   = 36;  // CORDIC residual angle, Q30
	localparam int UW   = 34;  // unit vector components, Q30
	localparam int RADW = 24;  // radius
	localparam int PRW  = UW + RADW + 1; // radius product
	localparam int DW   = 22;  // rounded difference, Q16
	localparam int SQW  = 35;  // one square
	localparam int VW   = 36;  // sum of squares
	localparam int RTW  = VW / 2; // square root
	localparam int SRW  = RTW + 2; // square root remainder
	localparam int QW   = 15;  // direction magnitude
	localparam int NW   = DW - 1 + QW; // dividend
	localparam int DRW  = NW - QW; // divider remainder
	localparam int DVW  = RTW + 2; // divisor

	localparam logic signed [AW-1:0] PI_Q14      = AW'(51472);
	localparam logic signed [AW-1:0] HALF_PI_Q14 = AW'(25736);
	localparam logic signed [XW-1:0] CORDIC_K    = 34'sh026DD3B6A;
	localparam logic signed [XW-1:0] Q30_ONE     = 34'sh040000000;
	localparam logic [QW-1:0]        DIR_ONE     = QW'(16384);

	// Arctangent of 2^-i in Q30.
	localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	// Configuration register indexes.
	localparam int CFG_IW = 8;
	localparam logic [CFG_IW-1:0] REG_RADIUS   = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] REG_ORIGIN_X = CFG_IW'(1);
	localparam logic [CFG_IW-1:0] REG_ORIGIN_Y = CFG_IW'(2);
	localparam logic [CFG_IW-1:0] REG_ORIGIN_Z = CFG_IW'(3);

	// Depth of the queue between front and back.
	localparam int QDEPTH = 2;

	// Configuration seen by the back end.
	typedef struct packed {
		logic [RADW-1:0]      radius;
		logic [2:0][31:0]     org;
	} cfg_t;

	// Classified word: angles el1, az1, el2, az2 after range reduction.
	typedef struct packed {
		logic [3:0][AW-1:0] ang;
		logic [3:0]         neg;
		logic [3:0]         zero;
	} fe_item_t;

	typedef struct packed {
		logic [3:0][XW-1:0] x;
		logic [3:0][XW-1:0] y;
		logic [3:0][ZW-1:0] z;
		logic [3:0]         neg;
		logic [3:0]         zero;
	} cordic_t;

	typedef struct packed {
		logic [2:0][UW-1:0] u1;
		logic [2:0][UW-1:0] u2;
	} mul_t;

	typedef struct packed {
		logic [2:0][PRW-1:0] pr;
		logic [2:0][DW-1:0]  d;
		logic                rzero;
	} prod_t;

	typedef struct packed {
		logic [2:0][31:0]    p;
		logic [2:0][DW-1:0]  d;
		logic [2:0][SQW-1:0] sq;
		logic                rzero;
	} pt_t;

	typedef struct packed {
		logic [2:0][31:0]   p;
		logic [2:0][DW-1:0] d;
		logic               degen;
		logic [VW-1:0]      val;
		logic [SRW-1:0]     srem;
		logic [RTW-1:0]     root;
	} sqrt_t;

	typedef struct packed {
		logic [2:0][31:0]    p;
		logic [2:0]          sgn;
		logic                degen;
		logic [DVW-1:0]      dv;
		logic [2:0][NW-1:0]  num;
		logic [2:0][DRW-1:0] rem;
		logic [2:0][QW-1:0]  q;
	} div_t;

endpackage
`default_nettype wire

>>> design/spr_in_if.sv
// Input channel carrying a pair of sphere points.
`default_nettype none
interface spr_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] start_elevation;
	logic [16:0] start_azimuth;
	logic [15:0] aim_elevation;
	logic [16:0] aim_azimuth;

	modport source (output valid, output start_elevation, output start_azimuth,
		output aim_elevation, output aim_azimuth, input ready);
	modport sink (input valid, input start_elevation, input start_azimuth,
		input aim_elevation, input aim_azimuth, output ready);
endinterface
`default_nettype wire

>>> design/spr_out_if.sv
// Output channel carrying the ray start point and direction.
`default_nettype none
interface spr_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] point_x;
	logic [31:0] point_y;
	logic [31:0] point_z;
	logic [15:0] dir_x;
	logic [15:0] dir_y;
	logic [15:0] dir_z;
	logic        degenerate;

	modport source (output valid, output point_x, output point_y, output point_z,
		output dir_x, output dir_y, output dir_z, output degenerate, input ready);
	modport sink (input valid, input point_x, input point_y, input point_z,
		input dir_x, input dir_y, input dir_z, input degenerate, output ready);
endinterface
`default_nettype wire

>>> design/spr_cfg_if.sv
// Configuration write channel.
`default_nettype none
interface spr_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/spr_front.sv
// Front end: accepts a word and reduces its four angles to the CORDIC range.
`default_nettype none
module spr_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	spr_in_if.sink             req,
	output spr_pkg::fe_item_t  item,
	output logic               item_valid,
	input  wire logic          item_ready
);

	spr_pkg::fe_item_t fe_d;
	spr_pkg::fe_item_t fe_s1;
	logic              v_s1;
	logic [3:0][spr_pkg::AW-1:0] raw;

	// Extend every angle to the common signed width.
	assign raw[0] = spr_pkg::AW'(req.start_elevation);
	assign raw[1] = {req.start_azimuth[16], req.start_azimuth};
	assign raw[2] = spr_pkg::AW'(req.aim_elevation);
	assign raw[3] = {req.aim_azimuth[16], req.aim_azimuth};

	// Fold angles beyond a quarter turn by half a turn and note the sign flip.
	always_comb begin
		for (int a = 0; a < 4; a++) begin
			if ($signed(raw[a]) > spr_pkg::HALF_PI_Q14) begin
				fe_d.ang[a] = raw[a] - spr_pkg::PI_Q14;
				fe_d.neg[a] = 1'b1;
			end else if ($signed(raw[a]) < -spr_pkg::HALF_PI_Q14) begin
				fe_d.ang[a] = raw[a] + spr_pkg::PI_Q14;
				fe_d.neg[a] = 1'b1;
			end else begin
				fe_d.ang[a] = raw[a];
				fe_d.neg[a] = 1'b0;
			end
			fe_d.zero[a] = (fe_d.ang[a] == '0);
		end
	end

	assign req.ready  = !v_s1 || item_ready;
	assign item       = fe_s1;
	assign item_valid = v_s1;

	// Front stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			fe_s1 <= fe_d;
		end
	end

endmodule
`default_nettype wire

>>> design/spr_queue.sv
// Short queue between the front end and the back end.
`default_nettype none
module spr_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push_valid,
	output logic                    push_ready,
	input  wire spr_pkg::fe_item_t  push_item,
	output logic                    pop_valid,
	input  wire logic               pop_ready,
	output spr_pkg::fe_item_t       pop_item
);

	localparam int PTRW = $clog2(spr_pkg::QDEPTH);
	localparam int CNTW = $clog2(spr_pkg::QDEPTH + 1);

	spr_pkg::fe_item_t mem_q [spr_pkg::QDEPTH];
	logic [PTRW-1:0]   wr_ptr_q;
	logic [PTRW-1:0]   rd_ptr_q;
	logic [CNTW-1:0]   cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != CNTW'(spr_pkg::QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(spr_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(spr_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

>>> design/spr_back.sv
// Back end: CORDIC, products, square root and division pipeline.
`default_nettype none
module spr_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire spr_pkg::fe_item_t  in_item,
	input  wire spr_pkg::cfg_t      cfg,
	spr_out_if.source               rsp
);

	localparam int NC = spr_pkg::CORDIC_ITERS;
	localparam int NS = spr_pkg::RTW;
	localparam int ND = spr_pkg::QW;

	logic en;

	// One CORDIC rotation on all four angles.
	function automatic spr_pkg::cordic_t cordic_step(spr_pkg::cordic_t c, int i);
		spr_pkg::cordic_t       r;
		logic signed [spr_pkg::XW-1:0] xs;
		logic signed [spr_pkg::XW-1:0] ys;
		logic signed [spr_pkg::ZW-1:0] at;
		r  = c;
		xs = '0;
		ys = '0;
		at = '0;
		for (int a = 0; a < 4; a++) begin
			xs = $signed(c.x[a]) >>> i;
			ys = $signed(c.y[a]) >>> i;
			at = $signed(spr_pkg::ZW'(spr_pkg::ATAN_TAB[i]));
			if (!c.z[a][spr_pkg::ZW-1]) begin
				r.x[a] = c.x[a] - ys;
				r.y[a] = c.y[a] + xs;
				r.z[a] = c.z[a] - at;
			end else begin
				r.x[a] = c.x[a] + ys;
				r.y[a] = c.y[a] - xs;
				r.z[a] = c.z[a] + at;
			end
		end
		return r;
	endfunction

	// Whole pipe advances unless the result register is held.
	assign en       = !rsp.valid || rsp.ready;
	assign in_ready = en;

	// CORDIC start values.
	spr_pkg::cordic_t c0;
	always_comb begin
		for (int a = 0; a < 4; a++) begin
			c0.x[a] = spr_pkg::CORDIC_K;
			c0.y[a] = '0;
			c0.z[a] = {{(spr_pkg::ZW - spr_pkg::AW - 16){in_item.ang[a][spr_pkg::AW-1]}},
				in_item.ang[a], 16'd0};
		end
		c0.neg  = in_item.neg;
		c0.zero = in_item.zero;
	end

	// CORDIC stages, one rotation each.
	spr_pkg::cordic_t cord_s [1:NC];
	logic [NC:0]      vc_s;
	assign vc_s[0] = in_valid;

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		spr_pkg::cordic_t cin;
		if (i == 0) begin : g_first
			assign cin = c0;
		end else begin : g_next
			assign cin = cord_s[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vc_s[i+1] <= 1'b0;
			end else if (en) begin
				vc_s[i+1] <= vc_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cord_s[i+1] <= cordic_step(cin, i);
			end
		end
	end

	// Fix up the CORDIC results and form the unit vectors.
	logic [3:0][spr_pkg::XW-1:0] sn;
	logic [3:0][spr_pkg::XW-1:0] cs;
	spr_pkg::mul_t m_d;
	spr_pkg::mul_t m_s;
	logic          vm_s;

	always_comb begin
		logic [spr_pkg::XW-1:0]         xv;
		logic [spr_pkg::XW-1:0]         yv;
		logic signed [2*spr_pkg::XW-1:0] pa;
		logic signed [2*spr_pkg::XW-1:0] pb;
		xv = '0;
		yv = '0;
		for (int a = 0; a < 4; a++) begin
			xv = cord_s[NC].zero[a] ? spr_pkg::Q30_ONE : cord_s[NC].x[a];
			yv = cord_s[NC].zero[a] ? '0 : cord_s[NC].y[a];
			cs[a] = cord_s[NC].neg[a] ? -xv : xv;
			sn[a] = cord_s[NC].neg[a] ? -yv : yv;
		end
		pa = '0;
		pb = '0;
		for (int p = 0; p < 2; p++) begin
			pa = $signed(sn[2*p]) * $signed(cs[2*p+1]);
			pb = $signed(sn[2*p]) * $signed(sn[2*p+1]);
			pa = (pa + (2*spr_pkg::XW)'(64'sd1 <<< 29)) >>> 30;
			pb = (pb + (2*spr_pkg::XW)'(64'sd1 <<< 29)) >>> 30;
			if (p == 0) begin
				m_d.u1[0] = pa[spr_pkg::UW-1:0];
				m_d.u1[1] = pb[spr_pkg::UW-1:0];
				m_d.u1[2] = cs[0];
			end else begin
				m_d.u2[0] = pa[spr_pkg::UW-1:0];
				m_d.u2[1] = pb[spr_pkg::UW-1:0];
				m_d.u2[2] = cs[2];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vm_s <= 1'b0;
		end else if (en) begin
			vm_s <= vc_s[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s <= m_d;
		end
	end

	// Radius products and rounded differences.
	spr_pkg::prod_t q_d;
	spr_pkg::prod_t q_s;
	logic           vq_s;

	always_comb begin
		logic signed [spr_pkg::UW:0] df;
		df = '0;
		for (int k = 0; k < 3; k++) begin
			q_d.pr[k] = spr_pkg::PRW'($signed(spr_pkg::PRW'($signed(m_s.u1[k]))) *
				$signed({1'b0, cfg.radius}));
			df = $signed({m_s.u2[k][spr_pkg::UW-1], m_s.u2[k]}) -
				$signed({m_s.u1[k][spr_pkg::UW-1], m_s.u1[k]});
			df = (df + (spr_pkg::UW+1)'(8192)) >>> 14;
			q_d.d[k] = df[spr_pkg::DW-1:0];
		end
		q_d.rzero = (cfg.radius == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vq_s <= 1'b0;
		end else if (en) begin
			vq_s <= vm_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s <= q_d;
		end
	end

	// Points with origin and saturation, and the squares.
	spr_pkg::pt_t r_d;
	spr_pkg::pt_t r_s;
	logic         vr_s;

	always_comb begin
		logic signed [spr_pkg::PRW-1:0]  rp;
		logic signed [spr_pkg::PRW-1:0]  sm;
		logic signed [2*spr_pkg::DW-1:0] sq;
		rp = '0;
		sm = '0;
		sq = '0;
		for (int k = 0; k < 3; k++) begin
			rp = ($signed(q_s.pr[k]) + spr_pkg::PRW'(64'sd1 <<< 29)) >>> 30;
			sm = rp + spr_pkg::PRW'($signed(cfg.org[k]));
			if (sm > spr_pkg::PRW'(64'sd2147483647)) begin
				r_d.p[k] = 32'h7FFF_FFFF;
			end else if (sm < -spr_pkg::PRW'(64'sd2147483648)) begin
				r_d.p[k] = 32'h8000_0000;
			end else begin
				r_d.p[k] = sm[31:0];
			end
			sq = $signed(q_s.d[k]) * $signed(q_s.d[k]);
			r_d.sq[k] = sq[spr_pkg::SQW-1:0];
		end
		r_d.d     = q_s.d;
		r_d.rzero = q_s.rzero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vr_s <= 1'b0;
		end else if (en) begin
			vr_s <= vq_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s <= r_d;
		end
	end

	// Sum of squares and the coincidence test.
	spr_pkg::sqrt_t s0_d;
	always_comb begin
		s0_d.p     = r_s.p;
		s0_d.d     = r_s.d;
		s0_d.val   = spr_pkg::VW'(r_s.sq[0]) + spr_pkg::VW'(r_s.sq[1]) +
			spr_pkg::VW'(r_s.sq[2]);
		s0_d.degen = r_s.rzero || (s0_d.val == '0);
		s0_d.srem  = '0;
		s0_d.root  = '0;
	end

	// Square root, one result bit per stage.
	spr_pkg::sqrt_t rt_s [0:NS];
	logic [NS:0]    vs_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vs_s[0] <= 1'b0;
		end else if (en) begin
			vs_s[0] <= vr_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s[0] <= s0_d;
		end
	end

	for (genvar j = 0; j < NS; j++) begin : g_sqrt
		spr_pkg::sqrt_t nx;
		always_comb begin
			logic [spr_pkg::SRW+1:0] t;
			logic [spr_pkg::SRW+1:0] tr;
			nx = rt_s[j];
			t  = {rt_s[j].srem, rt_s[j].val[spr_pkg::VW-1-2*j -: 2]};
			tr = (spr_pkg::SRW+2)'({rt_s[j].root, 2'b01});
			if (t >= tr) begin
				nx.srem = spr_pkg::SRW'(t - tr);
				nx.root = {rt_s[j].root[spr_pkg::RTW-2:0], 1'b1};
			end else begin
				nx.srem = spr_pkg::SRW'(t);
				nx.root = {rt_s[j].root[spr_pkg::RTW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vs_s[j+1] <= 1'b0;
			end else if (en) begin
				vs_s[j+1] <= vs_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[j+1] <= nx;
			end
		end
	end

	// Divider set-up: rounded magnitude over twice the length.
	spr_pkg::div_t d0_d;
	always_comb begin
		logic [spr_pkg::RTW-1:0] n;
		logic [spr_pkg::DW-1:0]  mf;
		logic [spr_pkg::DW-2:0]  mag;
		n   = rt_s[NS].degen ? spr_pkg::RTW'(1) : rt_s[NS].root;
		mf  = '0;
		mag = '0;
		d0_d.p     = rt_s[NS].p;
		d0_d.degen = rt_s[NS].degen;
		d0_d.dv    = {1'b0, n, 1'b0};
		for (int k = 0; k < 3; k++) begin
			d0_d.sgn[k] = rt_s[NS].d[k][spr_pkg::DW-1];
			mf  = d0_d.sgn[k] ? -rt_s[NS].d[k] : rt_s[NS].d[k];
			mag = mf[spr_pkg::DW-2:0];
			d0_d.num[k] = {mag, spr_pkg::QW'(0)} + spr_pkg::NW'(n);
			d0_d.rem[k] = d0_d.num[k][spr_pkg::NW-1:spr_pkg::QW];
			d0_d.q[k]   = '0;
		end
	end

	// Restoring division, one quotient bit per stage on all three components.
	spr_pkg::div_t dv_s [0:ND];
	logic [ND:0]   vd_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd_s[0] <= 1'b0;
		end else if (en) begin
			vd_s[0] <= vs_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= d0_d;
		end
	end

	for (genvar j = 0; j < ND; j++) begin : g_div
		spr_pkg::div_t nx;
		always_comb begin
			logic [spr_pkg::DRW:0] t;
			nx = dv_s[j];
			t  = '0;
			for (int k = 0; k < 3; k++) begin
				t = {dv_s[j].rem[k], dv_s[j].num[k][spr_pkg::QW-1-j]};
				if (t >= (spr_pkg::DRW+1)'(dv_s[j].dv)) begin
					nx.rem[k] = spr_pkg::DRW'(t - (spr_pkg::DRW+1)'(dv_s[j].dv));
					nx.q[k]   = {dv_s[j].q[k][spr_pkg::QW-2:0], 1'b1};
				end else begin
					nx.rem[k] = spr_pkg::DRW'(t);
					nx.q[k]   = {dv_s[j].q[k][spr_pkg::QW-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vd_s[j+1] <= 1'b0;
			end else if (en) begin
				vd_s[j+1] <= vd_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j+1] <= nx;
			end
		end
	end

	// Clamp, sign and mask the direction.
	logic [2:0][15:0] dir_d;
	always_comb begin
		logic [spr_pkg::QW-1:0] qc;
		qc = '0;
		for (int k = 0; k < 3; k++) begin
			qc = (dv_s[ND].q[k] > spr_pkg::DIR_ONE) ? spr_pkg::DIR_ONE : dv_s[ND].q[k];
			if (dv_s[ND].degen) begin
				dir_d[k] = '0;
			end else if (dv_s[ND].sgn[k]) begin
				dir_d[k] = -16'(qc);
			end else begin
				dir_d[k] = 16'(qc);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (en) begin
			rsp.valid <= vd_s[ND];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp.point_x    <= dv_s[ND].p[0];
			rsp.point_y    <= dv_s[ND].p[1];
			rsp.point_z    <= dv_s[ND].p[2];
			rsp.dir_x      <= dir_d[0];
			rsp.dir_y      <= dir_d[1];
			rsp.dir_z      <= dir_d[2];
			rsp.degenerate <= dv_s[ND].degen;
		end
	end

endmodule
`default_nettype wire

>>> design/spherical_pair_to_ray_unit.sv
// Top level of the spherical pair to ray unit.
//
// Unless stalled, the req channel takes one word per cycle: elevation and
// azimuth of a start point and of an aim point on a sphere, angles in radians
// Q3.14. The rsp channel returns one word for each: the start point in Q24.8
// (radius times the unit vector plus origin, saturated) and the unit
// direction toward the aim point in Q1.14, with degenerate set and a zero
// direction when the two points coincide or the radius is zero.
// The cfg channel writes radius and origin; it is always ready and is meant
// to be written while no word is in flight.
// Throughput is one word per cycle while rsp is not stalled. An accepted
// word passes the front register, the queue, the CORDIC stages, four
// arithmetic stages, the 18 square root stages, the divider set-up, the 15
// divider stages and the result register.
// When rsp is stalled the back pipeline holds; the two-entry queue and the
// front register then fill and req.ready falls. Reset empties the pipeline
// and sets radius to 1.0 and the origin to zero.
`default_nettype none
module spherical_pair_to_ray_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	spr_in_if.sink    req,
	spr_out_if.source rsp,
	spr_cfg_if.sink   cfg
);

	spr_pkg::cfg_t     cfg_q;
	spr_pkg::fe_item_t fe_item;
	logic              fe_valid;
	logic              fe_ready;
	spr_pkg::fe_item_t bk_item;
	logic              bk_valid;
	logic              bk_ready;

	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius <= spr_pkg::RADW'(256);
			cfg_q.org    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				spr_pkg::REG_RADIUS:   cfg_q.radius <= cfg.data[spr_pkg::RADW-1:0];
				spr_pkg::REG_ORIGIN_X: cfg_q.org[0] <= cfg.data;
				spr_pkg::REG_ORIGIN_Y: cfg_q.org[1] <= cfg.data;
				spr_pkg::REG_ORIGIN_Z: cfg_q.org[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	spr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.item       (fe_item),
		.item_valid (fe_valid),
		.item_ready (fe_ready)
	);

	spr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_item  (fe_item),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_item   (bk_item)
	);

	spr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (bk_valid),
		.in_ready (bk_ready),
		.in_item  (bk_item),
		.cfg      (cfg_q),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

>>> design/spr_checker.sv
// Port checker for the spherical pair to ray unit and its bind.
`default_nettype none
`include "spherical_pair_to_ray_unit_defines.svh"
module spr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] point_x,
	input wire logic [31:0] point_y,
	input wire logic [31:0] point_z,
	input wire logic [15:0] dir_x,
	input wire logic [15:0] dir_y,
	input wire logic [15:0] dir_z,
	input wire logic        degenerate
);

	logic [144:0] payload;
	logic         dir_zero;
	logic         dir_in_range;

	assign payload  = {point_x, point_y, point_z, dir_x, dir_y, dir_z, degenerate};
	assign dir_zero = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
	assign dir_in_range =
		($signed(dir_x) >= -16'sd16384) && ($signed(dir_x) <= 16'sd16384) &&
		($signed(dir_y) >= -16'sd16384) && ($signed(dir_y) <= 16'sd16384) &&
		($signed(dir_z) >= -16'sd16384) && ($signed(dir_z) <= 16'sd16384);

	// A stalled word stays offered and unchanged.
	`SPR_ASSERT_NEXT(a_valid_held, out_valid && !out_ready, out_valid)
	`SPR_ASSERT_NEXT(a_payload_held, out_valid && !out_ready, $stable(payload))
	// Coinciding points give a zero direction.
	`SPR_ASSERT_NOW(a_degen_zero, out_valid && degenerate, dir_zero)
	// A proper direction is nonzero and within unit range.
	`SPR_ASSERT_NOW(a_dir_unit, out_valid && !degenerate, !dir_zero && dir_in_range)

endmodule

bind spherical_pair_to_ray_unit spr_checker u_spr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.point_x    (rsp.point_x),
	.point_y    (rsp.point_y),
	.point_z    (rsp.point_z),
	.dir_x      (rsp.dir_x),
	.dir_y      (rsp.dir_y),
	.dir_z      (rsp.dir_z),
	.degenerate (rsp.degenerate)
);
`default_nettype wire
